// File: rtl/pclc_pkg.sv
// pclc_pkg: shared types and constants for the pixel cluster label cache.
// No dependencies; imported by pclc_cell, pixel_cluster_label_cache, pclc_checker and tb_top.

package pclc_pkg;

    // Fixed port field widths
    localparam int COL_W   = 8;
    localparam int ROW_W   = 10;
    localparam int LABEL_W = 10;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Result kind codes
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_MERGE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROWCHG,
        ST_FETCH,
        ST_STEP1,
        ST_STEP2,
        ST_STEP3,
        ST_FINAL
    } state_t;

    // Broadcast control to every column cell
    typedef struct packed {
        logic clr_top;   // empty the top row entry
        logic clr_cur;   // empty the current row entry
        logic copy;      // current row entry moves to top row
        logic relabel;   // replace absorbed label by survivor
        logic write;     // store pixel label at the addressed column
    } cell_ctl_t;

endpackage

// File: rtl/pixel_cluster_label_cache.sv
// pixel_cluster_label_cache: top level, row of column cells plus sequencer.
// Depends on pclc_pkg and pclc_cell.
//
// Usage
//   Input channel (in_valid/in_stall) carries one transfer per fired pixel,
//   in raster order, or a clear command at the start of a frame. Output
//   channel (out_valid/out_stall) returns zero to three merge notifications
//   (kind=1, surviving and absorbed label) followed by the pixel label
//   (kind=0, last=1). A clear command returns nothing.
// Sequence
//   A pixel passes row update, neighbor fetch, three neighbor steps and
//   final write before the next transfer is accepted; the pixel result is
//   registered at the final write. A clear ends after the row update, and a
//   column beyond the row goes from row update straight to final write.
//   in_stall is high while an item is in flight.
// Stall
//   One output register holds a result; a merge or final step waits while it
//   is full and stalled. The next pixel is accepted while the last pixel
//   result still waits to be taken.
// Reset
//   rst_n (async) empties both rows, zeroes the row index, drops out_valid.

module pixel_cluster_label_cache #(
    parameter int ROW_WIDTH  = 256,
    parameter int LABEL_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [pclc_pkg::COL_W-1:0]    column,
    input  logic [pclc_pkg::ROW_W-1:0]    row,
    input  logic [pclc_pkg::LABEL_W-1:0]  new_label,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [pclc_pkg::LABEL_W-1:0]  label,
    output logic [pclc_pkg::LABEL_W-1:0]  absorbed_label,
    output logic                          last
);
    import pclc_pkg::*;

    localparam int LB   = LABEL_BITS;
    localparam int CLOG = $clog2(ROW_WIDTH);
    // one spare bit so column and ROW_WIDTH compare without wrap
    localparam int CW   = ((CLOG > COL_W) ? CLOG : COL_W) + 1;

    // ---------------- sequencer and item registers ----------------
    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_idx_reg, row_idx_next;
    logic              cmd_reg, cmd_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [LB-1:0]     fresh_reg, fresh_next;

    // working label and the three neighbor labels
    logic [LB-1:0]     w_reg, w_next;
    logic [LB-1:0]     n1_reg, n1_next;
    logic [LB-1:0]     n2_reg, n2_next;
    logic [LB-1:0]     n3_reg, n3_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [LB-1:0]     label_reg, label_next;
    logic [LB-1:0]     absorbed_reg, absorbed_next;
    logic              last_reg, last_next;

    logic              in_acc;
    logic              out_free;
    logic              oor;
    logic              skip_row;
    logic [ROW_W:0]    idx_p1;

    // neighbor step
    logic [LB-1:0]     nb;
    logic              merge;
    logic              take_b;
    logic              advance;
    logic [LB-1:0]     fin_lab;

    // cell control
    cell_ctl_t         ctl;
    logic [CW:0]       pos;
    logic              out_load;
    logic              ld_kind;
    logic [LB-1:0]     ld_label;
    logic [LB-1:0]     ld_absorbed;
    logic              ld_last;

    // cell array wiring
    logic [LB-1:0]     cur_q    [ROW_WIDTH];
    logic [LB-1:0]     top_q    [ROW_WIDTH];
    logic [LB-1:0]     rd_tc    [ROW_WIDTH];
    logic [LB-1:0]     rd_l     [ROW_WIDTH];
    logic [LB-1:0]     rd_tl    [ROW_WIDTH];
    logic [LB-1:0]     rd_tr    [ROW_WIDTH];
    logic [LB-1:0]     rd_top_c, rd_left, rd_topleft, rd_topright;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign oor      = (col_reg >= CW'(ROW_WIDTH));
    assign idx_p1   = {1'b0, row_idx_reg} + (ROW_W + 1)'(1);
    assign skip_row = ({1'b0, row_reg} > idx_p1);

    // ---------------- column cells ----------------
    for (genvar i = 0; i < ROW_WIDTH; i++)
    begin : g_cell
        logic [LB-1:0] lc, lt, rt;
        if (i > 0)
        begin : g_l
            assign lc = cur_q[i-1];
            assign lt = top_q[i-1];
        end
        else
        begin : g_l0
            assign lc = '0;
            assign lt = '0;
        end
        if (i < ROW_WIDTH - 1)
        begin : g_r
            assign rt = top_q[i+1];
        end
        else
        begin : g_rn
            assign rt = '0;
        end

        pclc_cell #(
            .IDX (i),
            .LB  (LB),
            .CW  (CW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .col          (col_reg),
            .pos          (pos),
            .lab_a        (w_reg),
            .lab_b        (nb),
            .wr_label     (fin_lab),
            .left_cur_in  (lc),
            .left_top_in  (lt),
            .right_top_in (rt),
            .cur_out      (cur_q[i]),
            .top_out      (top_q[i]),
            .rd_top_c     (rd_tc[i]),
            .rd_left      (rd_l[i]),
            .rd_topleft   (rd_tl[i]),
            .rd_topright  (rd_tr[i])
        );
    end

    // at most one cell drives a nonzero window, so OR collects it
    always_comb
    begin
        rd_top_c    = '0;
        rd_left     = '0;
        rd_topleft  = '0;
        rd_topright = '0;
        for (int k = 0; k < ROW_WIDTH; k++)
        begin
            rd_top_c    = rd_top_c    | rd_tc[k];
            rd_left     = rd_left     | rd_l[k];
            rd_topleft  = rd_topleft  | rd_tl[k];
            rd_topright = rd_topright | rd_tr[k];
        end
    end

    // ---------------- neighbor step ----------------
    always_comb
    begin
        case (state_reg)
            ST_STEP1: begin nb = n1_reg; pos = {1'b0, col_reg}; end
            ST_STEP2: begin nb = n2_reg; pos = {1'b0, col_reg} - (CW + 1)'(1); end
            ST_STEP3: begin nb = n3_reg; pos = {1'b0, col_reg} + (CW + 1)'(1); end
            default:  begin nb = '0;     pos = {1'b0, col_reg}; end
        endcase
    end

    assign take_b  = (nb != '0) && ((w_reg == '0) || (w_reg == nb));
    assign merge   = (nb != '0) && (w_reg != '0) && (w_reg != nb);
    assign advance = !merge || out_free;
    assign fin_lab = oor ? '0 : ((w_reg == '0) ? fresh_reg : w_reg);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_ROWCHG;
                end
            end
            ST_ROWCHG:
            begin
                if (cmd_reg == CMD_CLEAR)
                begin
                    state_next = ST_IDLE;
                end
                else if (oor)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_STEP1;
            ST_STEP1:
            begin
                if (advance)
                begin
                    state_next = ST_STEP2;
                end
            end
            ST_STEP2:
            begin
                if (advance)
                begin
                    state_next = ST_STEP3;
                end
            end
            ST_STEP3:
            begin
                if (advance)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        ctl         = '0;
        out_load    = 1'b0;
        ld_kind     = KIND_PIXEL;
        ld_label    = '0;
        ld_absorbed = '0;
        ld_last     = 1'b0;
        case (state_reg)
            ST_ROWCHG:
            begin
                if (cmd_reg == CMD_CLEAR)
                begin
                    ctl.clr_top = 1'b1;
                    ctl.clr_cur = 1'b1;
                end
                else if (!oor && row_reg != row_idx_reg)
                begin
                    // skipped rows leave an empty top row
                    ctl.clr_top = skip_row;
                    ctl.copy    = !skip_row;
                    ctl.clr_cur = 1'b1;
                end
            end
            ST_STEP1, ST_STEP2, ST_STEP3:
            begin
                if (merge && out_free)
                begin
                    ctl.relabel = 1'b1;
                    out_load    = 1'b1;
                    ld_kind     = KIND_MERGE;
                    ld_label    = w_reg;
                    ld_absorbed = nb;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    ctl.write = !oor;
                    out_load  = 1'b1;
                    ld_label  = fin_lab;
                    ld_last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        row_idx_next = row_idx_reg;
        cmd_next     = cmd_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        fresh_next   = fresh_reg;
        w_next       = w_reg;
        n1_next      = n1_reg;
        n2_next      = n2_reg;
        n3_next      = n3_reg;
        if (in_acc)
        begin
            cmd_next   = command;
            col_next   = CW'(column);
            row_next   = row;
            fresh_next = LB'(new_label);
        end
        case (state_reg)
            ST_ROWCHG:
            begin
                if (cmd_reg == CMD_CLEAR)
                begin
                    row_idx_next = '0;
                end
                else if (!oor)
                begin
                    row_idx_next = row_reg;
                end
            end
            ST_FETCH:
            begin
                w_next  = rd_top_c;
                n1_next = rd_left;
                n2_next = rd_topleft;
                n3_next = rd_topright;
            end
            ST_STEP1, ST_STEP2, ST_STEP3:
            begin
                if (advance)
                begin
                    if (take_b)
                    begin
                        w_next = nb;
                    end
                    // top-right entry was fetched before this relabel
                    if (merge && n3_reg == nb)
                    begin
                        n3_next = w_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && out_stall);
        kind_next      = kind_reg;
        label_next     = label_reg;
        absorbed_next  = absorbed_reg;
        last_next      = last_reg;
        if (out_load)
        begin
            kind_next     = ld_kind;
            label_next    = ld_label;
            absorbed_next = ld_absorbed;
            last_next     = ld_last;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_idx_reg   <= row_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        fresh_reg    <= fresh_next;
        w_reg        <= w_next;
        n1_reg       <= n1_next;
        n2_reg       <= n2_next;
        n3_reg       <= n3_next;
        kind_reg     <= kind_next;
        label_reg    <= label_next;
        absorbed_reg <= absorbed_next;
        last_reg     <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign label          = LABEL_W'(label_reg);
    assign absorbed_label = LABEL_W'(absorbed_reg);
    assign last           = last_reg;

endmodule

// File: rtl/pclc_cell.sv
// pclc_cell: one column of the two-row label cache (top and current entry).
// Depends on pclc_pkg. Neighbor entries arrive from the adjacent cells.

module pclc_cell #(
    parameter int IDX = 0,
    parameter int LB  = 10,
    parameter int CW  = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pclc_pkg::cell_ctl_t ctl,
    input  logic [CW-1:0]       col,
    input  logic [CW:0]         pos,
    input  logic [LB-1:0]       lab_a,
    input  logic [LB-1:0]       lab_b,
    input  logic [LB-1:0]       wr_label,
    input  logic [LB-1:0]       left_cur_in,
    input  logic [LB-1:0]       left_top_in,
    input  logic [LB-1:0]       right_top_in,
    output logic [LB-1:0]       cur_out,
    output logic [LB-1:0]       top_out,
    output logic [LB-1:0]       rd_top_c,
    output logic [LB-1:0]       rd_left,
    output logic [LB-1:0]       rd_topleft,
    output logic [LB-1:0]       rd_topright
);
    import pclc_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [LB-1:0] top_reg, top_next;
    logic [LB-1:0] cur_reg, cur_next;
    logic          here;
    logic          below_pos;

    assign here      = (col == IDX_C);
    assign below_pos = ($signed({1'b0, IDX_C}) < $signed(pos));

    always_comb
    begin
        top_next = top_reg;
        if (ctl.clr_top)
        begin
            top_next = '0;
        end
        else if (ctl.copy)
        begin
            top_next = cur_reg;
        end
        else if (ctl.relabel && !below_pos && top_reg == lab_b)
        begin
            top_next = lab_a;
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (ctl.clr_cur)
        begin
            cur_next = '0;
        end
        else if (ctl.relabel && below_pos && cur_reg == lab_b)
        begin
            cur_next = lab_a;
        end
        else if (ctl.write && here)
        begin
            cur_next = wr_label;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            cur_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
            cur_reg <= cur_next;
        end
    end

    assign cur_out = cur_reg;
    assign top_out = top_reg;

    // Only the addressed column drives its window; the rest return zero
    assign rd_top_c    = here ? top_reg      : '0;
    assign rd_left     = here ? left_cur_in  : '0;
    assign rd_topleft  = here ? left_top_in  : '0;
    assign rd_topright = here ? right_top_in : '0;

endmodule

// File: rtl/pclc_checker.sv
// pclc_checker: port-level checks for pixel_cluster_label_cache, with bind.
// Depends on pclc_pkg; sees only the top-level ports.

module pclc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          command,
    input logic [pclc_pkg::COL_W-1:0]    column,
    input logic [pclc_pkg::ROW_W-1:0]    row,
    input logic [pclc_pkg::LABEL_W-1:0]  new_label,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          kind,
    input logic [pclc_pkg::LABEL_W-1:0]  label,
    input logic [pclc_pkg::LABEL_W-1:0]  absorbed_label,
    input logic                          last
);
    import pclc_pkg::*;

    // one item in flight: a transfer always blocks the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken back to back");

    // merge notices carry two distinct live labels and never close an item
    a_merge_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_MERGE |->
            !last && label != '0 && absorbed_label != '0 && label != absorbed_label)
        else $error("malformed merge result");

    // pixel result closes the item and has no absorbed label
    a_pixel_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_PIXEL |-> last && absorbed_label == '0)
        else $error("malformed pixel result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(kind) && $stable(label) && $stable(absorbed_label)
            && $stable(last))
        else $error("stalled result changed");

endmodule

bind pixel_cluster_label_cache pclc_checker u_pclc_checker (.*);

// File: tb/tb_top.sv
// tb_top: self-checking testbench for pixel_cluster_label_cache (two-row cluster label cache).
// Depends on pclc_pkg and the RTL top; scripted pixels first, then random frames,
// checked against a label predictor held inside this module or a typed-in label.
`timescale 1ns / 1ps

module tb_top;
    import pclc_pkg::*;

    localparam int ROW_CELLS     = 256;
    localparam int LABEL_BITS    = 10;
    localparam int RANDOM_ITEMS  = 148;
    localparam int DRAIN_AT      = 80;    // random transfer after which the sender waits
    localparam int LONG_HOLD     = 250;   // receiver hold-off, in cycles
    localparam int STALL_LIMIT   = 3000;  // cycles with no transfer before giving up
    localparam int TAIL_CYCLES   = 20;    // settling time after the last owed result is back
    localparam int SCRIPT_LEN    = 22;

    // One result transfer as seen on the output channel
    typedef struct packed {
        logic               kind;
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] absorbed;
        logic               last;
    } label_res_t;

    // One input transfer; when has_label is set the pixel label is typed in
    typedef struct packed {
        logic               cmd;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   rw;
        logic [LABEL_W-1:0] nl;
        logic               has_label;
        logic [LABEL_W-1:0] lbl;
    } pixel_item_t;

    // Scripted opening: extremes, skipped and backward rows, zero label, clears,
    // a merge between two top-row clusters.
    localparam pixel_item_t PIXEL_SCRIPT [SCRIPT_LEN] = '{
        // clear with junk in every other field
        '{CMD_CLEAR, 8'd255, 10'd1023, 10'd1023, 1'b0, 10'd0},
        // empty cache: first pixels take their new label or a left neighbor's
        '{CMD_PIXEL, 8'd0,   10'd0,    10'd1,    1'b1, 10'd1},
        '{CMD_PIXEL, 8'd255, 10'd0,    10'd1023, 1'b1, 10'd1023},
        '{CMD_PIXEL, 8'd1,   10'd0,    10'd5,    1'b0, 10'd0},
        // zero new label with no neighbor: label 0, column stays empty
        '{CMD_PIXEL, 8'd254, 10'd0,    10'd0,    1'b1, 10'd0},
        // next row: pixels touching the top row inherit its labels
        '{CMD_PIXEL, 8'd0,   10'd1,    10'd7,    1'b0, 10'd0},
        '{CMD_PIXEL, 8'd3,   10'd1,    10'd9,    1'b0, 10'd0},
        '{CMD_PIXEL, 8'd255, 10'd1,    10'd11,   1'b0, 10'd0},
        // skipped row: top row starts empty
        '{CMD_PIXEL, 8'd10,  10'd3,    10'd20,   1'b1, 10'd20},
        '{CMD_PIXEL, 8'd12,  10'd3,    10'd30,   1'b1, 10'd30},
        // bridges labels 20 and 30
        '{CMD_PIXEL, 8'd11,  10'd4,    10'd40,   1'b0, 10'd0},
        // row going backwards
        '{CMD_PIXEL, 8'd5,   10'd2,    10'd50,   1'b0, 10'd0},
        '{CMD_PIXEL, 8'd200, 10'd1023, 10'd1023, 1'b1, 10'd1023},
        '{CMD_PIXEL, 8'd201, 10'd1023, 10'd1,    1'b0, 10'd0},
        '{CMD_CLEAR, 8'd0,   10'd0,    10'd0,    1'b0, 10'd0},
        '{CMD_PIXEL, 8'd128, 10'd0,    10'd0,    1'b1, 10'd0},
        '{CMD_PIXEL, 8'd128, 10'd1,    10'd3,    1'b1, 10'd3},
        '{CMD_PIXEL, 8'd100, 10'd5,    10'd200,  1'b1, 10'd200},
        '{CMD_PIXEL, 8'd102, 10'd5,    10'd202,  1'b1, 10'd202},
        '{CMD_PIXEL, 8'd101, 10'd6,    10'd300,  1'b0, 10'd0},
        '{CMD_PIXEL, 8'd103, 10'd6,    10'd301,  1'b0, 10'd0},
        '{CMD_PIXEL, 8'd102, 10'd6,    10'd302,  1'b0, 10'd0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               command;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [LABEL_W-1:0] new_label;
    logic               out_valid;
    logic               out_stall;
    logic               kind;
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] absorbed_label;
    logic               last;

    // Predictor state: our own copy of both row stores and the row index
    logic [LABEL_W-1:0] top_lbl [ROW_CELLS];
    logic [LABEL_W-1:0] cur_lbl [ROW_CELLS];
    logic [ROW_W-1:0]   row_now;

    label_res_t pixel_outcome [$];   // results of the pixel just predicted
    label_res_t awaited [$];         // results still owed by the block, oldest first

    int  mismatches     = 0;
    int  pixels_sent    = 0;
    int  clears_sent    = 0;
    int  labels_seen    = 0;
    int  merges_seen    = 0;
    bit  calm           = 1'b0;      // no new idle gaps drawn on either side while set
    logic long_hold_req;
    bit  long_hold_done = 1'b0;

    pixel_cluster_label_cache #(
        .ROW_WIDTH  (ROW_CELLS),
        .LABEL_BITS (LABEL_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .column         (column),
        .row            (row),
        .new_label      (new_label),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .label          (label),
        .absorbed_label (absorbed_label),
        .last           (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------------
    // Label predictor
    // ---------------------------------------------------------------------

    function automatic void clear_cache_model();
        for (int i = 0; i < ROW_CELLS; i++)
        begin
            top_lbl[i] = '0;
            cur_lbl[i] = '0;
        end
        row_now = '0;
    endfunction

    // Fold neighbor label b into working label a at position pos. Two differing
    // labels produce a merge; the absorbed label is rewritten in the current row
    // left of pos and in the top row from pos on.
    function automatic logic [LABEL_W-1:0] join_labels(int pos, logic [LABEL_W-1:0] a,
                                                       logic [LABEL_W-1:0] b);
        label_res_t r;
        if (b == '0)
            return a;
        if (a == '0 || a == b)
            return b;
        r.kind     = KIND_MERGE;
        r.label    = a;
        r.absorbed = b;
        r.last     = 1'b0;
        pixel_outcome.push_back(r);
        for (int i = 0; i < pos && i < ROW_CELLS; i++)
            if (cur_lbl[i] == b)
                cur_lbl[i] = a;
        for (int i = (pos < 0) ? 0 : pos; i < ROW_CELLS; i++)
            if (top_lbl[i] == b)
                top_lbl[i] = a;
        return a;
    endfunction

    // Column is 8 bits wide and the row holds 256 cells, so a column beyond
    // the row cannot be presented on this configuration.
    function automatic void predict_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] rw,
                                          logic [LABEL_W-1:0] nl);
        int                 c;
        logic [LABEL_W-1:0] lab;
        logic [LABEL_W-1:0] nb;
        label_res_t         r;
        c = int'(col);
        pixel_outcome.delete();
        // New row: current row moves up, or the top row is empty after a gap
        if (rw != row_now)
        begin
            for (int i = 0; i < ROW_CELLS; i++)
            begin
                top_lbl[i] = (int'(rw) > int'(row_now) + 1) ? '0 : cur_lbl[i];
                cur_lbl[i] = '0;
            end
            row_now = rw;
        end
        // top, then left, top-left, top-right; each read sees prior relabels
        lab = top_lbl[c];
        nb  = (c > 0) ? cur_lbl[c - 1] : '0;
        lab = join_labels(c, lab, nb);
        nb  = (c > 0) ? top_lbl[c - 1] : '0;
        lab = join_labels(c - 1, lab, nb);
        nb  = (c < ROW_CELLS - 1) ? top_lbl[c + 1] : '0;
        lab = join_labels(c + 1, lab, nb);
        if (lab == '0)
            lab = nl;
        cur_lbl[c] = lab;
        r.kind     = KIND_PIXEL;
        r.label    = lab;
        r.absorbed = '0;
        r.last     = 1'b1;
        pixel_outcome.push_back(r);
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------------
    // Sender: one transfer, then the prediction, then an optional gap.
    // valid stays high into the next item when there is no gap, so no
    // edge ever sees two assignments to it.
    // ---------------------------------------------------------------------
    task automatic send_item(input pixel_item_t it);
        int         gap;
        label_res_t r;
        in_valid  <= 1'b1;
        command   <= it.cmd;
        column    <= it.col;
        row       <= it.rw;
        new_label <= it.nl;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (it.cmd == CMD_CLEAR)
        begin
            clear_cache_model();
            clears_sent++;
        end
        else
        begin
            predict_pixel(it.col, it.rw, it.nl);
            pixels_sent++;
            if (it.has_label)
            begin
                // label read straight off the scenario
                r.kind     = KIND_PIXEL;
                r.label    = it.lbl;
                r.absorbed = '0;
                r.last     = 1'b1;
                awaited.push_back(r);
            end
            else
                foreach (pixel_outcome[i])
                    awaited.push_back(pixel_outcome[i]);
        end
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver: checks each accepted result, then picks the next stall.
    // out_stall read right after the edge is the value that edge used.
    // ---------------------------------------------------------------------
    initial
    begin
        int         hold_left;
        label_res_t got;
        label_res_t want;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got.kind     = kind;
                got.label    = label;
                got.absorbed = absorbed_label;
                got.last     = last;
                if (awaited.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected: kind=%0d label=%0d absorbed=%0d last=%0d",
                             $time, got.kind, got.label, got.absorbed, got.last);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: mismatch: expected kind=%0d label=%0d absorbed=%0d last=%0d",
                                 $time, want.kind, want.label, want.absorbed, want.last);
                        $display("%0t:           actual   kind=%0d label=%0d absorbed=%0d last=%0d",
                                 $time, got.kind, got.label, got.absorbed, got.last);
                    end
                    if (want.kind == KIND_MERGE)
                        merges_seen++;
                    else
                        labels_seen++;
                end
            end
            // one long hold-off so the block fills up and stalls its input
            if (long_hold_req === 1'b1 && !long_hold_done)
            begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (hold_left == 0 && !calm)
                hold_left = idle_len();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, awaited.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Main stimulus
    // ---------------------------------------------------------------------
    initial
    begin
        pixel_item_t it;
        int          sent;
        int          rw;
        int          base;
        int          nrows;
        int          r;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        command       <= CMD_PIXEL;
        column        <= '0;
        row           <= '0;
        new_label     <= '0;
        long_hold_req <= 1'b0;
        clear_cache_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PIXEL_SCRIPT[i])
            send_item(PIXEL_SCRIPT[i]);

        // receiver goes quiet for a long stretch while the sender keeps offering
        long_hold_req <= 1'b1;

        // Random frames: mostly a clear, then a few rows of pixels in a narrow
        // column window so clusters touch and merge. Some frames skip the
        // clear, some pixels land anywhere or out of column order.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                it     = '0;
                it.cmd = CMD_CLEAR;
                it.col = COL_W'($urandom);
                it.rw  = ROW_W'($urandom);
                it.nl  = LABEL_W'($urandom);
                send_item(it);
                sent++;
            end
            rw    = ($urandom_range(0, 4) == 0) ? $urandom_range(1000, 1023)
                                                : $urandom_range(0, 900);
            nrows = $urandom_range(3, 7);
            r     = $urandom_range(0, 5);
            base  = (r == 0) ? 0 : (r == 1) ? 246 : $urandom_range(0, 246);
            for (int y = 0; y < nrows && sent < RANDOM_ITEMS; y++)
            begin
                for (int k = 0; k < 10 && sent < RANDOM_ITEMS; k++)
                begin
                    if ($urandom_range(0, 99) < 45)
                    begin
                        it     = '0;
                        it.cmd = CMD_PIXEL;
                        r      = $urandom_range(0, 19);
                        it.col = (r == 0) ? COL_W'($urandom_range(0, 255))
                               : (r == 1) ? COL_W'(base + $urandom_range(0, 9))
                                          : COL_W'(base + k);
                        it.rw  = ROW_W'(rw);
                        r      = $urandom_range(0, 19);
                        it.nl  = (r == 0) ? LABEL_W'(0) : (r == 1) ? LABEL_W'(1023)
                                                    : LABEL_W'($urandom_range(1, 1023));
                        send_item(it);
                        sent++;
                        if (sent == DRAIN_AT)
                        begin
                            // sender pauses until every owed result is back
                            in_valid <= 1'b0;
                            do
                                @(posedge clk);
                            while (awaited.size() != 0);
                        end
                    end
                end
                // next row: mostly +1, sometimes a skip, now and then backwards
                r = $urandom_range(0, 15);
                if (r == 0)
                    rw = (rw > 3) ? rw - 3 : 0;
                else if (r < 3)
                    rw = rw + $urandom_range(2, 4);
                else
                    rw = rw + 1;
                if (rw > 1023)
                    rw = 1023;
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d pixel transfers and %0d clears over scripted and random frames.",
                 pixels_sent, clears_sent);
        $display("Checked %0d pixel labels and %0d merge notifications, %0d mismatches.",
                 labels_seen, merges_seen, mismatches);
        if (mismatches == 0 && awaited.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/pclc_pkg.sv
rtl/pclc_cell.sv
rtl/pixel_cluster_label_cache.sv
rtl/pclc_checker.sv
tb/tb_top.sv
